### src/coordinate_graph_shortest_path_defines.svh
// Assertion macros for the RTL.
`ifndef COORDINATE_GRAPH_SHORTEST_PATH_DEFINES_SVH
`define COORDINATE_GRAPH_SHORTEST_PATH_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define CGSP_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define CGSP_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

### src/cgsp_pkg.sv
`timescale 1ns / 1ps
package cgsp_pkg;

   localparam int DIST_W = 48;
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NODE_FULL = 2'd1;
   localparam logic [1:0] ST_EDGE_FULL = 2'd2;
   localparam logic [1:0] ST_NO_PATH   = 2'd3;

   localparam logic MODE_ADD   = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef enum logic [18:0] {
      S_IDLE    = 19'h00001,
      S_FIND    = 19'h00002,
      S_FINDCHK = 19'h00004,
      S_ADDEC   = 19'h00008,
      S_ADDW    = 19'h00010,
      S_QINIT   = 19'h00020,
      S_POPSCAN = 19'h00040,
      S_POPRD   = 19'h00080,
      S_POPCHK  = 19'h00100,
      S_POPDO   = 19'h00200,
      S_EDGERD  = 19'h00400,
      S_EDGECHK = 19'h00800,
      S_RELAX   = 19'h01000,
      S_TRACE   = 19'h02000,
      S_TRACERD = 19'h04000,
      S_EMITRD  = 19'h08000,
      S_EMIT    = 19'h10000,
      S_EMITSK  = 19'h20000,
      S_RESULT  = 19'h40000
   } state_type;

endpackage

### src/coordinate_graph_shortest_path.sv
`timescale 1ns / 1ps
`include "coordinate_graph_shortest_path_defines.svh"
// Shortest path over a graph of nodes named by coordinates.
// Input channel req_*: mode 0 stores an undirected weighted edge, mode 1 asks
// for the shortest path from (a_lat, a_lng) to (b_lat, b_lng).
// Result channel rsp_*: an add gives one result with its status; a query gives
// one result per path node from source to destination, each with the total
// distance, or one no-path result; rsp_last marks the final result.
// One item is worked at a time; req_stall stays high until the last result
// of the current item has been transferred.
// Node lookup walks the node memory entry by entry; an add then writes any
// new nodes and both directions of the edge. A query runs, for each pop, a
// frontier scan over every filled entry plus an edge scan over every stored
// directed edge, each through a registered memory read, then traces the path
// back from the destination and emits it node by node.
// Reset clears node and edge counts; memories keep their contents and need
// no clearing pass. A stalled result holds its register and the block waits.
module coordinate_graph_shortest_path #(
   parameter int MAX_NODES = 64,
   parameter int MAX_EDGES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic signed [30:0] req_a_lat,
   input  logic signed [31:0] req_a_lng,
   input  logic signed [30:0] req_b_lat,
   input  logic signed [31:0] req_b_lng,
   input  logic [31:0] req_weight,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic signed [30:0] rsp_point_lat,
   output logic signed [31:0] rsp_point_lng,
   output logic [47:0] rsp_distance,
   output logic        rsp_last
);
   localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int NCW = $clog2(MAX_NODES + 1);
   localparam int ES = 2 * MAX_EDGES;
   localparam int EW = $clog2(ES);
   localparam int ECW = $clog2(ES + 1);
   localparam int FD = ES + 1;
   localparam int FW = $clog2(FD);
   localparam int FCW = $clog2(FD + 1);
   localparam int DW = cgsp_pkg::DIST_W;

   // memories
   logic signed [30:0] nlat_mem [MAX_NODES];
   logic signed [31:0] nlng_mem [MAX_NODES];
   logic [NW-1:0] efrom_mem [ES];
   logic [NW-1:0] eto_mem [ES];
   logic [31:0]   ewt_mem [ES];
   logic [DW-1:0] fdist_mem [FD];
   logic [NW-1:0] fnode_mem [FD];
   logic          fval_mem [FD];
   logic [DW-1:0] best_mem [MAX_NODES];
   logic [NW-1:0] par_mem [MAX_NODES];
   logic [NW-1:0] stk_mem [MAX_NODES];
   logic [MAX_NODES-1:0] reached_ff;

   cgsp_pkg::state_type state_ff;
   logic [NCW-1:0] ncount_ff;
   logic [ECW-1:0] ecount_ff;
   logic [FCW-1:0] ffill_ff;

   logic mode_ff;
   logic signed [30:0] alat_ff, blat_ff;
   logic signed [31:0] alng_ff, blng_ff;
   logic [31:0] wt_ff;

   // lookup
   logic [NCW-1:0] fidx_ff;
   logic [NW-1:0]  ia_ff, ib_ff;
   logic           fa_ff, fb_ff;
   logic signed [30:0] rlat_ff;
   logic signed [31:0] rlng_ff;

   // search
   logic [FCW-1:0] fscan_ff;
   logic           bfound_ff;
   logic [FW-1:0]  bidx_ff;
   logic [DW-1:0]  bdist_ff;
   logic signed [30:0] blat_best_ff;
   logic signed [31:0] blng_best_ff;
   logic [DW-1:0]  fd_rd_ff;
   logic [NW-1:0]  fn_rd_ff;
   logic           fv_rd_ff;
   logic [NW-1:0]  u_ff;
   logic [DW-1:0]  du_ff;
   logic [ECW-1:0] escan_ff;
   logic [NW-1:0]  ef_rd_ff, et_rd_ff;
   logic [31:0]    ew_rd_ff;
   logic [DW-1:0]  bv_rd_ff;
   logic [DW-1:0]  nd_ff;
   logic [NW-1:0]  v_ff;
   logic           vreach_ff;
   logic [NW-1:0]  at_ff, prd_ff;
   logic [NCW-1:0] n_ff, k_ff;
   logic [NW-1:0]  sk_rd_ff;
   logic [DW-1:0]  dfin_ff;

   logic rsp_valid_ff;
   logic [1:0] rsp_status_ff;
   logic signed [30:0] rsp_lat_ff;
   logic signed [31:0] rsp_lng_ff;
   logic [DW-1:0] rsp_dist_ff;
   logic rsp_last_ff;

   logic req_take, rsp_free, rsp_load;
   assign req_stall = (state_ff != cgsp_pkg::S_IDLE) || rsp_valid_ff;
   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = (state_ff == cgsp_pkg::S_EMIT) ||
                     ((state_ff == cgsp_pkg::S_RESULT) && rsp_free);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_point_lat = rsp_lat_ff;
   assign rsp_point_lng = rsp_lng_ff;
   assign rsp_distance = rsp_dist_ff;
   assign rsp_last = rsp_last_ff;

   logic same;
   assign same = (alat_ff == blat_ff) && (alng_ff == blng_ff);

   // node need and candidate compare
   logic [1:0] need;
   always_comb begin
      need = {1'b0, !fa_ff} + {1'b0, (!fb_ff && !same)};
   end

   logic [DW:0] sum;
   assign sum = {1'b0, du_ff} + {{(DW-31){1'b0}}, ew_rd_ff};

   logic cand_less;
   always_comb begin
      if (!bfound_ff) cand_less = 1'b1;
      else if (fd_rd_ff != bdist_ff) cand_less = fd_rd_ff < bdist_ff;
      else if (rlat_ff != blat_best_ff) cand_less = rlat_ff < blat_best_ff;
      else cand_less = rlng_ff < blng_best_ff;
   end

   // in POPRD, EMITRD and EDGECHK the read address comes from a registered read of the previous cycle
   logic [NW-1:0] naddr, baddr;
   always_comb begin
      case (state_ff)
         cgsp_pkg::S_POPRD: naddr = fn_rd_ff;
         cgsp_pkg::S_EMITRD: naddr = sk_rd_ff;
         default: naddr = fidx_ff[NW-1:0];
      endcase
      case (state_ff)
         cgsp_pkg::S_EDGECHK: baddr = et_rd_ff;
         cgsp_pkg::S_POPSCAN: baddr = u_ff;
         default: baddr = ib_ff;
      endcase
   end

   // memory ports
   always_ff @(posedge clock) begin
      rlat_ff <= nlat_mem[naddr];
      rlng_ff <= nlng_mem[naddr];
      fd_rd_ff <= fdist_mem[fscan_ff[FW-1:0]];
      fn_rd_ff <= fnode_mem[fscan_ff[FW-1:0]];
      fv_rd_ff <= fval_mem[fscan_ff[FW-1:0]];
      ef_rd_ff <= efrom_mem[escan_ff[EW-1:0]];
      et_rd_ff <= eto_mem[escan_ff[EW-1:0]];
      ew_rd_ff <= ewt_mem[escan_ff[EW-1:0]];
      bv_rd_ff <= best_mem[baddr];
      prd_ff   <= par_mem[at_ff];
      sk_rd_ff <= stk_mem[NW'(n_ff - 1'b1 - k_ff)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cgsp_pkg::S_IDLE;
         ncount_ff <= '0;
         ecount_ff <= '0;
         rsp_valid_ff <= 1'b0;
         reached_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && rsp_stall);
         case (state_ff)
            cgsp_pkg::S_IDLE: begin
               if (req_take) begin
                  mode_ff <= req_mode;
                  alat_ff <= req_a_lat; alng_ff <= req_a_lng;
                  blat_ff <= req_b_lat; blng_ff <= req_b_lng;
                  wt_ff <= req_weight;
                  fidx_ff <= '0; fa_ff <= 1'b0; fb_ff <= 1'b0;
                  state_ff <= cgsp_pkg::S_FIND;
               end
            end
            cgsp_pkg::S_FIND: begin
               if (mode_ff == cgsp_pkg::MODE_QUERY && same) begin
                  rsp_status_ff <= cgsp_pkg::ST_OK;
                  rsp_lat_ff <= alat_ff; rsp_lng_ff <= alng_ff;
                  rsp_dist_ff <= '0; rsp_last_ff <= 1'b1;
                  state_ff <= cgsp_pkg::S_RESULT;
               end else if (fidx_ff >= ncount_ff) begin
                  state_ff <= (mode_ff == cgsp_pkg::MODE_ADD) ? cgsp_pkg::S_ADDEC
                                                            : cgsp_pkg::S_QINIT;
               end else begin
                  state_ff <= cgsp_pkg::S_FINDCHK;
               end
            end
            cgsp_pkg::S_FINDCHK: begin
               if (!fa_ff && rlat_ff == alat_ff && rlng_ff == alng_ff) begin
                  fa_ff <= 1'b1; ia_ff <= fidx_ff[NW-1:0];
               end
               if (!fb_ff && rlat_ff == blat_ff && rlng_ff == blng_ff) begin
                  fb_ff <= 1'b1; ib_ff <= fidx_ff[NW-1:0];
               end
               fidx_ff <= fidx_ff + 1'b1;
               state_ff <= cgsp_pkg::S_FIND;
            end
            cgsp_pkg::S_ADDEC: begin
               rsp_lat_ff <= '0; rsp_lng_ff <= '0;
               rsp_dist_ff <= '0; rsp_last_ff <= 1'b1;
               if ({1'b0, ncount_ff} + (NCW+1)'(need) > (NCW+1)'(MAX_NODES)) begin
                  rsp_status_ff <= cgsp_pkg::ST_NODE_FULL;
                  state_ff <= cgsp_pkg::S_RESULT;
               end else if ({1'b0, ecount_ff} + (ECW+1)'(2) > (ECW+1)'(ES)) begin
                  rsp_status_ff <= cgsp_pkg::ST_EDGE_FULL;
                  state_ff <= cgsp_pkg::S_RESULT;
               end else begin
                  rsp_status_ff <= cgsp_pkg::ST_OK;
                  if (!fa_ff) begin
                     nlat_mem[ncount_ff[NW-1:0]] <= alat_ff;
                     nlng_mem[ncount_ff[NW-1:0]] <= alng_ff;
                     ia_ff <= ncount_ff[NW-1:0];
                     if (same) ib_ff <= ncount_ff[NW-1:0];
                     ncount_ff <= ncount_ff + 1'b1;
                  end else if (same) ib_ff <= ia_ff;
                  state_ff <= cgsp_pkg::S_ADDW;
               end
            end
            cgsp_pkg::S_ADDW: begin
               logic [NW-1:0] b;
               b = ib_ff;
               if (!same && !fb_ff) begin
                  nlat_mem[ncount_ff[NW-1:0]] <= blat_ff;
                  nlng_mem[ncount_ff[NW-1:0]] <= blng_ff;
                  b = ncount_ff[NW-1:0];
                  ncount_ff <= ncount_ff + 1'b1;
               end
               efrom_mem[ecount_ff[EW-1:0]] <= ia_ff;
               eto_mem[ecount_ff[EW-1:0]] <= b;
               ewt_mem[ecount_ff[EW-1:0]] <= wt_ff;
               efrom_mem[EW'(ecount_ff + 1'b1)] <= b;
               eto_mem[EW'(ecount_ff + 1'b1)] <= ia_ff;
               ewt_mem[EW'(ecount_ff + 1'b1)] <= wt_ff;
               ecount_ff <= ecount_ff + 2'd2;
               state_ff <= cgsp_pkg::S_RESULT;
            end
            cgsp_pkg::S_QINIT: begin
               if (!fa_ff || !fb_ff) begin
                  rsp_status_ff <= cgsp_pkg::ST_NO_PATH;
                  rsp_lat_ff <= '0; rsp_lng_ff <= '0;
                  rsp_dist_ff <= '0; rsp_last_ff <= 1'b1;
                  state_ff <= cgsp_pkg::S_RESULT;
               end else begin
                  reached_ff <= {{(MAX_NODES-1){1'b0}}, 1'b1} << ia_ff;
                  best_mem[ia_ff] <= '0;
                  fdist_mem[0] <= '0; fnode_mem[0] <= ia_ff; fval_mem[0] <= 1'b1;
                  ffill_ff <= FCW'(1);
                  fscan_ff <= '0; bfound_ff <= 1'b0;
                  state_ff <= cgsp_pkg::S_POPSCAN;
               end
            end
            cgsp_pkg::S_POPSCAN: begin
               if (fscan_ff >= ffill_ff) state_ff <= cgsp_pkg::S_POPDO;
               else state_ff <= cgsp_pkg::S_POPRD;
            end
            cgsp_pkg::S_POPRD: state_ff <= cgsp_pkg::S_POPCHK;
            cgsp_pkg::S_POPCHK: begin
               if (fv_rd_ff && cand_less) begin
                  bfound_ff <= 1'b1; bidx_ff <= fscan_ff[FW-1:0];
                  bdist_ff <= fd_rd_ff; u_ff <= fn_rd_ff;
                  blat_best_ff <= rlat_ff; blng_best_ff <= rlng_ff;
               end
               fscan_ff <= fscan_ff + 1'b1;
               state_ff <= cgsp_pkg::S_POPSCAN;
            end
            cgsp_pkg::S_POPDO: begin
               if (!bfound_ff || u_ff == ib_ff) begin
                  at_ff <= ib_ff; n_ff <= '0;
                  state_ff <= cgsp_pkg::S_TRACE;
               end else begin
                  fval_mem[bidx_ff] <= 1'b0;
                  du_ff <= bv_rd_ff;
                  escan_ff <= '0;
                  state_ff <= cgsp_pkg::S_EDGERD;
               end
            end
            cgsp_pkg::S_EDGERD: begin
               if (escan_ff >= ecount_ff) begin
                  fscan_ff <= '0; bfound_ff <= 1'b0;
                  state_ff <= cgsp_pkg::S_POPSCAN;
               end else state_ff <= cgsp_pkg::S_EDGECHK;
            end
            cgsp_pkg::S_EDGECHK: begin
               nd_ff <= sum[DW] ? cgsp_pkg::DIST_MAX : sum[DW-1:0];
               v_ff <= et_rd_ff;
               vreach_ff <= reached_ff[et_rd_ff];
               if (ef_rd_ff == u_ff) state_ff <= cgsp_pkg::S_RELAX;
               else begin
                  escan_ff <= escan_ff + 1'b1;
                  state_ff <= cgsp_pkg::S_EDGERD;
               end
            end
            cgsp_pkg::S_RELAX: begin
               // best distance of v was read during the check cycle
               if (!vreach_ff || bv_rd_ff > nd_ff) begin
                  reached_ff[v_ff] <= 1'b1;
                  best_mem[v_ff] <= nd_ff;
                  par_mem[v_ff] <= u_ff;
                  if (ffill_ff < FCW'(FD)) begin
                     fdist_mem[ffill_ff[FW-1:0]] <= nd_ff;
                     fnode_mem[ffill_ff[FW-1:0]] <= v_ff;
                     fval_mem[ffill_ff[FW-1:0]] <= 1'b1;
                     ffill_ff <= ffill_ff + 1'b1;
                  end
               end
               escan_ff <= escan_ff + 1'b1;
               state_ff <= cgsp_pkg::S_EDGERD;
            end
            cgsp_pkg::S_TRACE: begin
               if (!reached_ff[ib_ff]) begin
                  rsp_status_ff <= cgsp_pkg::ST_NO_PATH;
                  rsp_lat_ff <= '0; rsp_lng_ff <= '0;
                  rsp_dist_ff <= '0; rsp_last_ff <= 1'b1;
                  state_ff <= cgsp_pkg::S_RESULT;
               end else if (at_ff != ia_ff && n_ff < NCW'(MAX_NODES - 1)) begin
                  stk_mem[n_ff[NW-1:0]] <= at_ff;
                  n_ff <= n_ff + 1'b1;
                  state_ff <= cgsp_pkg::S_TRACERD;
               end else begin
                  stk_mem[n_ff[NW-1:0]] <= ia_ff;
                  n_ff <= n_ff + 1'b1;
                  k_ff <= '0;
                  state_ff <= cgsp_pkg::S_EMITSK;
               end
            end
            cgsp_pkg::S_TRACERD: begin
               at_ff <= prd_ff;
               state_ff <= cgsp_pkg::S_TRACE;
            end
            cgsp_pkg::S_EMITSK: begin
               // best distance of the destination, read in the previous cycle
               dfin_ff <= bv_rd_ff;
               state_ff <= cgsp_pkg::S_EMITRD;
            end
            cgsp_pkg::S_EMITRD: begin
               if (rsp_free) state_ff <= cgsp_pkg::S_EMIT;
            end
            cgsp_pkg::S_EMIT: begin
               rsp_status_ff <= cgsp_pkg::ST_OK;
               rsp_lat_ff <= rlat_ff; rsp_lng_ff <= rlng_ff;
               rsp_dist_ff <= dfin_ff;
               rsp_last_ff <= (k_ff + 1'b1 == n_ff);
               k_ff <= k_ff + 1'b1;
               state_ff <= (k_ff + 1'b1 == n_ff) ? cgsp_pkg::S_IDLE : cgsp_pkg::S_EMITSK;
            end
            cgsp_pkg::S_RESULT: begin
               if (rsp_free) state_ff <= cgsp_pkg::S_IDLE;
            end
            default: state_ff <= cgsp_pkg::S_IDLE;
         endcase
      end
   end

   `CGSP_ASSERT_IMPL(a_one_hot, clock, reset, 1'b1, $onehot(state_ff), "state not one-hot")
   `CGSP_ASSERT_IMPL(a_counts, clock, reset, 1'b1,
      ncount_ff <= NCW'(MAX_NODES) && ecount_ff <= ECW'(ES), "count overflow")
   `CGSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_distance), "stalled result changed")
endmodule
